// ===== rtl/core/longest_alternating_subsequence_assert.svh =====
// Assertion macros shared by the alternating subsequence block
`ifndef LONGEST_ALTERNATING_SUBSEQUENCE_ASSERT_SVH
`define LONGEST_ALTERNATING_SUBSEQUENCE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LAS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("las assertion failed");
`define LAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("las assertion failed");
`else
`define LAS_ASSERT_SAME(lbl, ante, cons)
`define LAS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/las_pkg.sv =====
// Types, constants and controller commands of the alternating subsequence block
package las_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [1:0] DIR_EITHER = 2'd0;
    localparam logic [1:0] DIR_UP     = 2'd1;
    localparam logic [1:0] DIR_DOWN   = 2'd2;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE  = 5'd0;
    localparam t_op OP_LOAD  = 5'd1;
    localparam t_op OP_INIT  = 5'd2;
    localparam t_op OP_IRD   = 5'd3;
    localparam t_op OP_ILAT  = 5'd4;
    localparam t_op OP_JRD   = 5'd5;
    localparam t_op OP_JEV   = 5'd6;
    localparam t_op OP_WRD   = 5'd7;
    localparam t_op OP_WEV   = 5'd8;
    localparam t_op OP_CEV   = 5'd9;
    localparam t_op OP_IWB   = 5'd10;
    localparam t_op OP_SINIT = 5'd11;
    localparam t_op OP_SRD   = 5'd12;
    localparam t_op OP_SEV   = 5'd13;
    localparam t_op OP_FINIT = 5'd14;
    localparam t_op OP_FRD   = 5'd15;
    localparam t_op OP_FEV   = 5'd16;
    localparam t_op OP_ERD   = 5'd17;
    localparam t_op OP_EVR   = 5'd18;
    localparam t_op OP_EOUT  = 5'd19;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               is_last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] chosen_value;
        logic [5:0]         chosen_index;
        logic               end_of_run;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic n_one;
        logic tie;
        logic j_last;
        logic i_last;
        logic walk_done;
        logic sel_hit;
        logic have;
        logic fill_done;
        logic emit_last;
    } t_stat;

endpackage

// ===== rtl/core/longest_alternating_subsequence.sv =====
// Top level of the longest alternating subsequence block
// Usage:
//   Input items (i_item: sample_value, is_last) are taken at a rising edge with
//   start high and busy low. Items are stored one per cycle; busy stays low
//   while loading. Up to MAX_LEN values are kept; later ones are dropped and
//   the overflow field of every result of that sequence reads 1.
//   An item with is_last set raises busy and starts the run over the stored
//   n values. The run reads each value i, then reads and evaluates every
//   j below i, walking both chains back when two chains tie in length;
//   it then selects over the n ends (plus tie walks), rebuilds the chosen
//   chain of length L, and emits each result with an index read, a value
//   read and an output step. The chain store has one read port per walker.
//   Results appear on o_result with o_strobe high for exactly one cycle each,
//   first element first, end_of_run on the last. The receiver cannot stall.
//   busy drops in the cycle that shows the final result.
//   Reset (synchronous, active low) empties the store and clears the flag.
module longest_alternating_subsequence import las_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output t_out o_result,
    output logic o_strobe
);
    t_op   op;
    t_stat stat;

    las_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_last (i_item.is_last),
        .i_stat    (stat),
        .o_op      (op),
        .o_busy    (busy)
    );

    las_dp #(.MAX_LEN(MAX_LEN), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_sample (i_item.sample_value),
        .o_stat   (stat),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );
endmodule

// ===== rtl/core/las_ram.sv =====
// Generic single write, single read RAM with registered read data
module las_ram #(
    parameter int W = 8,
    parameter int D = 64,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/las_ctrl.sv =====
// Sequencer: load, dynamic program, selection, chain fill and emit phases
`include "longest_alternating_subsequence_assert.svh"
module las_ctrl import las_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_is_last,
    input  t_stat i_stat,
    output t_op   o_op,
    output logic  o_busy
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_INIT  = 5'd1;
    localparam logic [4:0] S_IRD   = 5'd2;
    localparam logic [4:0] S_ILAT  = 5'd3;
    localparam logic [4:0] S_JRD   = 5'd4;
    localparam logic [4:0] S_JEV   = 5'd5;
    localparam logic [4:0] S_WRD   = 5'd6;
    localparam logic [4:0] S_WEV   = 5'd7;
    localparam logic [4:0] S_IWB   = 5'd8;
    localparam logic [4:0] S_SINIT = 5'd9;
    localparam logic [4:0] S_SRD   = 5'd10;
    localparam logic [4:0] S_SEV   = 5'd11;
    localparam logic [4:0] S_CRD   = 5'd12;
    localparam logic [4:0] S_CEV   = 5'd13;
    localparam logic [4:0] S_FINIT = 5'd14;
    localparam logic [4:0] S_FRD   = 5'd15;
    localparam logic [4:0] S_FEV   = 5'd16;
    localparam logic [4:0] S_ERD   = 5'd17;
    localparam logic [4:0] S_EVR   = 5'd18;
    localparam logic [4:0] S_EOUT  = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op = OP_LOAD;
                    if (i_is_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_op    = OP_INIT;
                n_state = i_stat.n_one ? S_SINIT : S_IRD;
            end
            S_IRD: begin
                o_op    = OP_IRD;
                n_state = S_ILAT;
            end
            S_ILAT: begin
                o_op    = OP_ILAT;
                n_state = S_JRD;
            end
            S_JRD: begin
                o_op    = OP_JRD;
                n_state = S_JEV;
            end
            S_JEV: begin
                o_op = OP_JEV;
                if (i_stat.tie) begin
                    n_state = S_WRD;
                end else begin
                    n_state = i_stat.j_last ? S_IWB : S_JRD;
                end
            end
            S_WRD: begin
                o_op    = OP_WRD;
                n_state = S_WEV;
            end
            S_WEV: begin
                o_op = OP_WEV;
                if (i_stat.walk_done) begin
                    n_state = i_stat.j_last ? S_IWB : S_JRD;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_IWB: begin
                o_op    = OP_IWB;
                n_state = i_stat.i_last ? S_SINIT : S_IRD;
            end
            S_SINIT: begin
                o_op    = OP_SINIT;
                n_state = S_SRD;
            end
            S_SRD: begin
                o_op    = OP_SRD;
                n_state = S_SEV;
            end
            S_SEV: begin
                o_op = OP_SEV;
                if (i_stat.sel_hit && i_stat.have) begin
                    n_state = S_CRD;
                end else begin
                    n_state = i_stat.i_last ? S_FINIT : S_SRD;
                end
            end
            S_CRD: begin
                o_op    = OP_WRD;
                n_state = S_CEV;
            end
            S_CEV: begin
                o_op = OP_CEV;
                if (i_stat.walk_done) begin
                    n_state = i_stat.i_last ? S_FINIT : S_SRD;
                end else begin
                    n_state = S_CRD;
                end
            end
            S_FINIT: begin
                o_op    = OP_FINIT;
                n_state = S_FRD;
            end
            S_FRD: begin
                o_op    = OP_FRD;
                n_state = S_FEV;
            end
            S_FEV: begin
                o_op    = OP_FEV;
                n_state = i_stat.fill_done ? S_ERD : S_FRD;
            end
            S_ERD: begin
                o_op    = OP_ERD;
                n_state = S_EVR;
            end
            S_EVR: begin
                o_op    = OP_EVR;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                o_op    = OP_EOUT;
                n_state = i_stat.emit_last ? S_IDLE : S_ERD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `LAS_ASSERT_NEXT(a_last_starts_run, r_state == S_IDLE && i_start && i_is_last, r_state == S_INIT)
    `LAS_ASSERT_NEXT(a_walk_loops, r_state == S_WEV && !i_stat.walk_done, r_state == S_WRD)
    `LAS_ASSERT_NEXT(a_emit_ends, r_state == S_EOUT && i_stat.emit_last, r_state == S_IDLE)
endmodule

// ===== rtl/core/las_dp.sv =====
// Datapath: value and chain stores, chain walker, counters and result register
`include "longest_alternating_subsequence_assert.svh"
module las_dp import las_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic [31:0] i_sample,
    output t_stat       o_stat,
    output t_out        o_result,
    output logic        o_strobe
);
    localparam int IW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int LW = CW;
    localparam int NW = LW + IW + 3;
    localparam int VW = VALUE_WIDTH;

    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic          r_strobe;
    t_out          r_out;

    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic signed [VW-1:0] r_vi;
    logic [LW-1:0] r_cur_len;
    logic [IW-1:0] r_cur_pred;
    logic          r_cur_hp;
    logic [1:0]    r_cur_dir;
    logic [1:0]    r_tdir;
    logic [LW-1:0] r_best_len;
    logic [IW-1:0] r_best_idx;
    logic          r_have;
    logic [IW-1:0] r_wa;
    logic [IW-1:0] r_wb;
    logic          r_bless;
    logic [IW-1:0] r_pos;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_eidx;

    logic          val_we;
    logic [IW-1:0] val_raddr;
    logic [VW-1:0] val_wdata;
    logic [VW-1:0] val_rdata;
    logic          node_we;
    logic [IW-1:0] node_waddr;
    logic [NW-1:0] node_wdata;
    logic [IW-1:0] a_raddr;
    logic [NW-1:0] a_rdata;
    logic [NW-1:0] b_rdata;
    logic [IW-1:0] idx_rdata;

    logic [VW+31:0] in_ext;
    logic [VW+31:0] out_ext;
    logic [IW+5:0]  idx_ext;

    logic [LW-1:0] a_len;
    logic [IW-1:0] a_pred;
    logic          a_hp;
    logic [1:0]    a_dir;
    logic [IW-1:0] b_pred;
    logic signed [VW-1:0] vj;
    logic          lt;
    logic          gt;
    logic          ext;
    logic [1:0]    tdir;
    logic [LW-1:0] cand;
    logic          grow;
    logic          tie;
    logic          room;
    logic          walk_done;
    logic          less_final;
    logic          i_last;
    logic          j_last;
    logic          emit_last;

    assign in_ext  = {{VW{1'b0}}, i_sample};
    assign out_ext = {32'd0, val_rdata};
    assign idx_ext = {6'd0, r_eidx};

    assign a_len  = a_rdata[NW-1 -: LW];
    assign a_pred = a_rdata[IW+2 -: IW];
    assign a_hp   = a_rdata[2];
    assign a_dir  = a_rdata[1:0];
    assign b_pred = b_rdata[IW+2 -: IW];
    assign vj     = val_rdata;

    // strict compares: equal values never extend each other
    assign lt   = (r_vi < vj);
    assign gt   = (vj < r_vi);
    assign ext  = (lt && a_dir != DIR_UP) || (gt && a_dir != DIR_DOWN);
    assign tdir = lt ? DIR_UP : DIR_DOWN;
    assign cand = a_len + LW'(1);
    assign grow = ext && (r_cur_len < cand);
    assign tie  = ext && (r_cur_len == cand);

    assign room      = (r_cnt < CW'(MAX_LEN));
    assign i_last    = ((CW'(r_i) + CW'(1)) == r_cnt);
    assign j_last    = ((r_j + IW'(1)) == r_i);
    assign emit_last = ((LW'(r_k) + LW'(1)) == r_best_len);

    // walking back in lockstep, the last difference seen is the first one from the front
    assign walk_done  = !a_hp || (r_wa == r_wb);
    assign less_final = (r_wa != r_wb) ? (r_wb < r_wa) : r_bless;

    always_comb begin
        unique case (i_op)
            OP_IRD:  val_raddr = r_i;
            OP_EVR:  val_raddr = idx_rdata;
            default: val_raddr = r_j;
        endcase
        unique case (i_op)
            OP_JRD:  a_raddr = r_j;
            OP_SRD:  a_raddr = r_i;
            default: a_raddr = r_wa;
        endcase
    end

    assign val_we     = (i_op == OP_LOAD) && room;
    assign val_wdata  = in_ext[VW-1:0];
    assign node_we    = (i_op == OP_INIT) || (i_op == OP_IWB);
    assign node_waddr = (i_op == OP_INIT) ? '0 : r_i;
    assign node_wdata = (i_op == OP_INIT) ? {LW'(1), IW'(0), 1'b0, DIR_EITHER}
                                          : {r_cur_len, r_cur_pred, r_cur_hp, r_cur_dir};

    las_ram #(.W(VW), .D(MAX_LEN)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (val_wdata),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    las_ram #(.W(NW), .D(MAX_LEN)) u_node_ram_a (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    las_ram #(.W(NW), .D(MAX_LEN)) u_node_ram_b (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (r_wb),
        .o_rdata (b_rdata)
    );

    las_ram #(.W(IW), .D(MAX_LEN)) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (i_op == OP_FEV),
        .i_waddr (r_pos),
        .i_wdata (r_wa),
        .i_raddr (r_k),
        .o_rdata (idx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_op == OP_EOUT);
            if (i_op == OP_LOAD) begin
                if (room) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end else if (i_op == OP_EOUT && emit_last) begin
                r_cnt  <= '0;
                r_drop <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_INIT: begin
                r_best_len <= LW'(1);
                r_i        <= IW'(1);
            end
            OP_ILAT: begin
                r_vi       <= val_rdata;
                r_cur_len  <= LW'(1);
                r_cur_pred <= '0;
                r_cur_hp   <= 1'b0;
                r_cur_dir  <= DIR_EITHER;
                r_j        <= '0;
            end
            OP_JEV: begin
                r_tdir <= tdir;
                if (grow) begin
                    r_cur_len  <= cand;
                    r_cur_pred <= r_j;
                    r_cur_hp   <= 1'b1;
                    r_cur_dir  <= tdir;
                end
                if (tie) begin
                    r_wa    <= r_cur_pred;
                    r_wb    <= r_j;
                    r_bless <= 1'b0;
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            OP_WEV, OP_CEV: begin
                if (r_wa != r_wb) begin
                    r_bless <= (r_wb < r_wa);
                end
                if (walk_done) begin
                    if (i_op == OP_WEV) begin
                        if (less_final) begin
                            r_cur_pred <= r_j;
                            r_cur_dir  <= r_tdir;
                        end
                        r_j <= r_j + IW'(1);
                    end else begin
                        if (less_final) begin
                            r_best_idx <= r_i;
                        end
                        r_i <= r_i + IW'(1);
                    end
                end else begin
                    r_wa <= a_pred;
                    r_wb <= b_pred;
                end
            end
            OP_IWB: begin
                if (r_cur_len > r_best_len) begin
                    r_best_len <= r_cur_len;
                end
                r_i <= r_i + IW'(1);
            end
            OP_SINIT: begin
                r_i    <= '0;
                r_have <= 1'b0;
            end
            OP_SEV: begin
                if (a_len == r_best_len && r_have) begin
                    r_wa    <= r_best_idx;
                    r_wb    <= r_i;
                    r_bless <= 1'b0;
                end else begin
                    if (a_len == r_best_len) begin
                        r_best_idx <= r_i;
                        r_have     <= 1'b1;
                    end
                    r_i <= r_i + IW'(1);
                end
            end
            OP_FINIT: begin
                r_wa  <= r_best_idx;
                r_pos <= IW'(r_best_len - LW'(1));
                r_k   <= '0;
            end
            OP_FEV: begin
                if (a_hp) begin
                    r_wa  <= a_pred;
                    r_pos <= r_pos - IW'(1);
                end
            end
            OP_EVR: begin
                r_eidx <= idx_rdata;
            end
            OP_EOUT: begin
                r_out.chosen_value <= out_ext[31:0];
                r_out.chosen_index <= idx_ext[5:0];
                r_out.end_of_run   <= emit_last;
                r_out.overflow     <= r_drop;
                r_k                <= r_k + IW'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_stat.n_one     = (r_cnt == CW'(1));
    assign o_stat.tie       = tie;
    assign o_stat.j_last    = j_last;
    assign o_stat.i_last    = i_last;
    assign o_stat.walk_done = walk_done;
    assign o_stat.sel_hit   = (a_len == r_best_len);
    assign o_stat.have      = r_have;
    assign o_stat.fill_done = !a_hp;
    assign o_stat.emit_last = emit_last;

    assign o_result = r_out;
    assign o_strobe = r_strobe;

    `LAS_ASSERT_NEXT(a_strobe_gap, r_strobe, !r_strobe)
    `LAS_ASSERT_SAME(a_cnt_bound, 1'b1, r_cnt <= CW'(MAX_LEN))
    `LAS_ASSERT_NEXT(a_full_drops, i_op == OP_LOAD && !room, r_drop)
endmodule
